// ===== sv/gpyq_pkg.sv =====
package gpyq_pkg;

  localparam int PALETTE_ENTRIES = 512;
  localparam int PAL_IDX_W       = 9;
  localparam int WORD_W          = 16;
  localparam int QUAD_N          = 4;
  localparam int SAMPLE_SHIFT    = 7;
  localparam int CHROMA_SHIFT    = 2;
  localparam int LUMA_RAMP_SHIFT = 7;
  localparam int CB_RAMP_SHIFT   = 6;
  localparam int CR_RAMP_SHIFT   = 5;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t luma;
    word_t cb;
    word_t cr;
  } pal_entry_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUAD  = 1'b1
  } op_t;

  function automatic pal_entry_t ramp_entry(input logic [PAL_IDX_W-1:0] idx);
    word_t      i;
    pal_entry_t e;
    i      = {{(WORD_W-PAL_IDX_W){idx[PAL_IDX_W-1]}}, idx};
    e.luma = i <<< LUMA_RAMP_SHIFT;
    e.cb   = (-i) <<< CB_RAMP_SHIFT;
    e.cr   = i <<< CR_RAMP_SHIFT;
    return e;
  endfunction

endpackage

// ===== sv/gpyq_if.sv =====
interface gpyq_in_if;
  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [8:0]            entry_index;
  logic signed [15:0]    entry_luma;
  logic signed [15:0]    entry_cb;
  logic signed [15:0]    entry_cr;
  logic signed [15:0]    pixel_top_left;
  logic signed [15:0]    pixel_top_right;
  logic signed [15:0]    pixel_bottom_left;
  logic signed [15:0]    pixel_bottom_right;

  modport source (
    output valid, operation, entry_index, entry_luma, entry_cb, entry_cr,
           pixel_top_left, pixel_top_right, pixel_bottom_left, pixel_bottom_right,
    input  ready
  );
  modport sink (
    input  valid, operation, entry_index, entry_luma, entry_cb, entry_cr,
           pixel_top_left, pixel_top_right, pixel_bottom_left, pixel_bottom_right,
    output ready
  );
endinterface

interface gpyq_out_if;
  logic                  valid;
  logic                  ready;
  logic signed [15:0]    luma_top_left;
  logic signed [15:0]    luma_top_right;
  logic signed [15:0]    luma_bottom_left;
  logic signed [15:0]    luma_bottom_right;
  logic signed [15:0]    chroma_cb;
  logic signed [15:0]    chroma_cr;

  modport source (
    output valid, luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
           chroma_cb, chroma_cr,
    input  ready
  );
  modport sink (
    input  valid, luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
           chroma_cb, chroma_cr,
    output ready
  );
endinterface

// ===== sv/grey_palette_to_yv12_quad.sv =====
// A quad's result goes through the palette read register, then the result register.
// Throughput: one item per cycle unless the output stalls or the palette loads;
// palette writes and quads interleave freely.
// Reset: synchronous, active low; clears control, then a pass over every entry loads the
// default ramp into the four palette banks, input ready stays low during that pass.
module grey_palette_to_yv12_quad #(
  parameter int PaletteEntries = gpyq_pkg::PALETTE_ENTRIES
) (
  input  logic        clk,
  input  logic        rst_n,
  gpyq_in_if.sink     in_chan,
  gpyq_out_if.source  out_chan
);

  localparam int IdxW = $clog2(PaletteEntries);

  logic                                           in_xfer;
  logic                                           quad_xfer;
  logic                                           wr_xfer;
  logic                                           pal_busy;
  logic                                           mix_take;
  logic                                           s1_valid_r;
  logic                                           s1_valid_nxt;
  logic [gpyq_pkg::QUAD_N-1:0][IdxW-1:0]          rd_idx;
  gpyq_pkg::pal_entry_t                           wr_entry;
  gpyq_pkg::pal_entry_t [gpyq_pkg::QUAD_N-1:0]    rd_entry;

  assign in_chan.ready = !pal_busy && (!s1_valid_r || mix_take);
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign quad_xfer     = in_xfer && (in_chan.operation == gpyq_pkg::OP_QUAD);
  assign wr_xfer       = in_xfer && (in_chan.operation == gpyq_pkg::OP_WRITE);

  always_comb begin
    wr_entry.luma = in_chan.entry_luma;
    wr_entry.cb   = in_chan.entry_cb;
    wr_entry.cr   = in_chan.entry_cr;
    rd_idx[0] = in_chan.pixel_top_left[gpyq_pkg::SAMPLE_SHIFT +: IdxW];
    rd_idx[1] = in_chan.pixel_top_right[gpyq_pkg::SAMPLE_SHIFT +: IdxW];
    rd_idx[2] = in_chan.pixel_bottom_left[gpyq_pkg::SAMPLE_SHIFT +: IdxW];
    rd_idx[3] = in_chan.pixel_bottom_right[gpyq_pkg::SAMPLE_SHIFT +: IdxW];
  end

  always_comb begin
    if (quad_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (mix_take) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  gpyq_palette #(
    .PaletteEntries(PaletteEntries)
  ) u_palette (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_xfer),
    .wr_idx   (in_chan.entry_index[IdxW-1:0]),
    .wr_entry (wr_entry),
    .rd_en    (quad_xfer),
    .rd_idx   (rd_idx),
    .rd_entry (rd_entry),
    .busy     (pal_busy)
  );

  gpyq_mix u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (s1_valid_r),
    .entries  (rd_entry),
    .take     (mix_take),
    .out_chan (out_chan)
  );

  a_no_xfer_while_loading: assert property (@(posedge clk) disable iff (!rst_n)
    pal_busy |-> !in_chan.ready)
    else $error("input ready during palette load");

  a_quad_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    quad_xfer |=> s1_valid_r)
    else $error("quad transfer lost before read stage");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    wr_xfer |=> !s1_valid_r)
    else $error("palette write produced a pending result");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !mix_take) |=> (s1_valid_r && $stable(rd_entry)))
    else $error("read stage dropped or changed under stall");

endmodule

// ===== sv/gpyq_palette.sv =====
module gpyq_palette #(
  parameter int PaletteEntries = gpyq_pkg::PALETTE_ENTRIES,
  localparam int IdxW = $clog2(PaletteEntries)
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic                                               wr_en,
  input  logic [IdxW-1:0]                                    wr_idx,
  input  gpyq_pkg::pal_entry_t                               wr_entry,
  input  logic                                               rd_en,
  input  logic [gpyq_pkg::QUAD_N-1:0][IdxW-1:0]              rd_idx,
  output gpyq_pkg::pal_entry_t [gpyq_pkg::QUAD_N-1:0]        rd_entry,
  output logic                                               busy
);

  logic                 clr_busy_r;
  logic [IdxW-1:0]      clr_idx_r;
  logic                 we;
  logic [IdxW-1:0]      wa;
  gpyq_pkg::pal_entry_t wd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == IdxW'(PaletteEntries - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_comb begin
    we = clr_busy_r || wr_en;
    wa = clr_busy_r ? clr_idx_r : wr_idx;
    wd = clr_busy_r ? gpyq_pkg::ramp_entry(gpyq_pkg::PAL_IDX_W'(clr_idx_r)) : wr_entry;
  end

  assign busy = clr_busy_r;

  for (genvar b = 0; b < gpyq_pkg::QUAD_N; b++) begin : g_bank
    gpyq_pkg::pal_entry_t mem [PaletteEntries];
    gpyq_pkg::pal_entry_t rdata_r;

    always_ff @(posedge clk) begin
      if (we) begin
        mem[wa] <= wd;
      end
    end

    always_ff @(posedge clk) begin
      if (rd_en) begin
        rdata_r <= mem[rd_idx[b]];
      end
    end

    assign rd_entry[b] = rdata_r;
  end

endmodule

// ===== sv/gpyq_mix.sv =====
module gpyq_mix (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         in_valid,
  input  gpyq_pkg::pal_entry_t [gpyq_pkg::QUAD_N-1:0]  entries,
  output logic                                         take,
  gpyq_out_if.source                                   out_chan
);

  logic                                         out_valid_r;
  gpyq_pkg::word_t [gpyq_pkg::QUAD_N-1:0]       luma_r;
  gpyq_pkg::word_t                              cb_r;
  gpyq_pkg::word_t                              cr_r;
  gpyq_pkg::word_t                              cb_nxt;
  gpyq_pkg::word_t                              cr_nxt;

  always_comb begin
    cb_nxt = '0;
    cr_nxt = '0;
    for (int b = 0; b < gpyq_pkg::QUAD_N; b++) begin
      cb_nxt = cb_nxt + ($signed(entries[b].cb) >>> gpyq_pkg::CHROMA_SHIFT);
      cr_nxt = cr_nxt + ($signed(entries[b].cr) >>> gpyq_pkg::CHROMA_SHIFT);
    end
  end

  assign take = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_valid) begin
      for (int b = 0; b < gpyq_pkg::QUAD_N; b++) begin
        luma_r[b] <= entries[b].luma;
      end
      cb_r <= cb_nxt;
      cr_r <= cr_nxt;
    end
  end

  assign out_chan.valid             = out_valid_r;
  assign out_chan.luma_top_left     = luma_r[0];
  assign out_chan.luma_top_right    = luma_r[1];
  assign out_chan.luma_bottom_left  = luma_r[2];
  assign out_chan.luma_bottom_right = luma_r[3];
  assign out_chan.chroma_cb         = cb_r;
  assign out_chan.chroma_cr         = cr_r;

endmodule
